[sv/dsdd_pkg.sv]
// Shared widths, stage count and sine table for the double-sine degree-day core.
package dsdd_pkg;

	localparam int TEMP_W      = 16;
	localparam int EXCESS_W    = 16;
	localparam int OUT_W       = 18;
	localparam int SAMPLES_DEF = 12;
	localparam int HALF_STAGES = 7;

	localparam int SINE_ENTRIES = 12;

	// Configuration register indexes.
	localparam logic [0:0] REG_LOWER = 1'b0;
	localparam logic [0:0] REG_UPPER = 1'b1;

	// sin(pi * (j / 12 - 1/2)) in Q1.15.
	localparam logic signed [15:0] SINE_Q15 [SINE_ENTRIES] = '{
		-16'sd32768, -16'sd31651, -16'sd28378, -16'sd23170, -16'sd16384, -16'sd8481,
		16'sd0, 16'sd8481, 16'sd16384, 16'sd23170, 16'sd28378, 16'sd31651
	};

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [EXCESS_W-1:0]      excess_t;
	typedef logic [HALF_STAGES:1]     stage_en_t;

endpackage

[sv/dsdd_half.sv]
// Seven-stage pipeline that computes the thermal excess of one half-day.
module dsdd_half #(
	parameter int SAMPLES_PER_HALF = dsdd_pkg::SAMPLES_DEF
) (
	input  logic                clk,
	input  dsdd_pkg::stage_en_t stage_en,
	input  dsdd_pkg::temp_t     s,
	input  dsdd_pkg::temp_t     e,
	input  dsdd_pkg::temp_t     lo,
	input  dsdd_pkg::temp_t     hi,
	output dsdd_pkg::excess_t   excess
);
	import dsdd_pkg::*;

	localparam logic [1:0] CLS_ZERO    = 2'd0;
	localparam logic [1:0] CLS_FULL    = 2'd1;
	localparam logic [1:0] CLS_FLAT    = 2'd2;
	localparam logic [1:0] CLS_SAMPLED = 2'd3;

	localparam int N      = SAMPLES_PER_HALF;
	localparam int GROUPS = (N + 3) / 4;
	localparam int GRP_W  = EXCESS_W + 2;
	localparam int SUM_W  = EXCESS_W + 1 + $clog2(N);
	localparam int DIV    = 2 * N;
	localparam int MUL    = (1 << SUM_W) / DIV;
	localparam int QW     = 17;
	localparam int PROD_W = 2 * SUM_W;

	// Stage 1: classify and form mean and amplitude.
	logic [1:0]         cls_c;
	excess_t            fix_c;
	logic signed [16:0] diff_c;
	logic signed [16:0] lo_dif_c;
	logic signed [16:0] hi_dif_c;

	always_comb begin
		diff_c   = {s[15], s} - {e[15], e};
		lo_dif_c = {s[15], s} - {lo[15], lo};
		hi_dif_c = {hi[15], hi} - {lo[15], lo};
		if (s <= lo && e <= lo) begin
			cls_c = CLS_ZERO;
			fix_c = '0;
		end else if (s >= hi && e >= hi) begin
			cls_c = CLS_FULL;
			fix_c = hi_dif_c[EXCESS_W-1:0];
		end else if (s == e) begin
			cls_c = CLS_FLAT;
			fix_c = lo_dif_c[EXCESS_W-1:0];
		end else begin
			cls_c = CLS_SAMPLED;
			fix_c = '0;
		end
	end

	logic [1:0]         cls_s1, cls_s2, cls_s3, cls_s4, cls_s5, cls_s6;
	excess_t            fix_s1, fix_s2, fix_s3, fix_s4, fix_s5, fix_s6;
	logic signed [16:0] mean_s1, mean_s2;
	logic [15:0]        ampl_s1;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			cls_s1  <= cls_c;
			fix_s1  <= fix_c;
			mean_s1 <= {s[15], s} + {e[15], e};
			ampl_s1 <= diff_c[16] ? 16'(-diff_c) : diff_c[15:0];
		end
		if (stage_en[2]) begin
			cls_s2  <= cls_s1;
			fix_s2  <= fix_s1;
			mean_s2 <= mean_s1;
		end
		if (stage_en[3]) begin
			cls_s3 <= cls_s2;
			fix_s3 <= fix_s2;
		end
		if (stage_en[4]) begin
			cls_s4 <= cls_s3;
			fix_s4 <= fix_s3;
		end
		if (stage_en[5]) begin
			cls_s5 <= cls_s4;
			fix_s5 <= fix_s4;
		end
		if (stage_en[6]) begin
			cls_s6 <= cls_s5;
			fix_s6 <= fix_s5;
		end
	end

	// Stages 2 and 3: one multiplier lane per sample, then round and clamp.
	logic signed [32:0] prod_s2 [N];
	excess_t            samp_s3 [N];
	logic signed [17:0] lo18;
	logic signed [17:0] hi18;

	assign lo18 = 18'(lo);
	assign hi18 = 18'(hi);

	for (genvar k = 0; k < N; k++) begin : g_lane
		localparam int IDX = (k * SINE_ENTRIES) / SAMPLES_PER_HALF;
		logic signed [33:0] exact_c;
		logic signed [17:0] t_c;
		logic signed [17:0] clamp_c;
		logic signed [17:0] rel_c;

		always_comb begin
			exact_c = (34'(mean_s2) <<< 15) + 34'(prod_s2[k]) + 34'sd32768;
			t_c     = exact_c[33:16];
			if (t_c < lo18) begin
				clamp_c = lo18;
			end else if (t_c > hi18) begin
				clamp_c = hi18;
			end else begin
				clamp_c = t_c;
			end
			rel_c = clamp_c - lo18;
		end

		always_ff @(posedge clk) begin
			if (stage_en[2]) begin
				prod_s2[k] <= 33'($signed({1'b0, ampl_s1})) * 33'(SINE_Q15[IDX]);
			end
			if (stage_en[3]) begin
				samp_s3[k] <= rel_c[EXCESS_W-1:0];
			end
		end
	end

	// Stage 4: sums of four lanes each. Stage 5: total plus rounding bias.
	logic [GRP_W-1:0] grp_c [GROUPS];
	logic [GRP_W-1:0] grp_s4 [GROUPS];
	logic [SUM_W-1:0] tot_c;
	logic [SUM_W-1:0] tot_s5, tot_s6;

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_c[g] = '0;
			for (int j = 0; j < 4; j++) begin
				if (g * 4 + j < N) begin
					grp_c[g] = grp_c[g] + GRP_W'(samp_s3[g * 4 + j]);
				end
			end
		end
		tot_c = SUM_W'(N);
		for (int g = 0; g < GROUPS; g++) begin
			tot_c = tot_c + SUM_W'(grp_s4[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			grp_s4 <= grp_c;
		end
		if (stage_en[5]) begin
			tot_s5 <= tot_c;
		end
	end

	// Stage 6: quotient estimate by reciprocal, low by at most one.
	logic [PROD_W-1:0] recip_c;
	logic [QW-1:0]     q_s6;

	assign recip_c = PROD_W'(tot_s5) * PROD_W'(MUL);

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			q_s6   <= recip_c[SUM_W +: QW];
			tot_s6 <= tot_s5;
		end
	end

	// Stage 7: one correction step, then pick the result for the class.
	logic [SUM_W-1:0] rem_c;
	logic [QW-1:0]    q_fix_c;
	excess_t          excess_s7;

	always_comb begin
		rem_c   = tot_s6 - SUM_W'(q_s6) * SUM_W'(DIV);
		q_fix_c = (rem_c >= SUM_W'(DIV)) ? q_s6 + QW'(1) : q_s6;
	end

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			excess_s7 <= (cls_s6 == CLS_SAMPLED) ? q_fix_c[EXCESS_W-1:0] : fix_s6;
		end
	end

	assign excess = excess_s7;

endmodule

[sv/double_sine_degree_day_core.sv]
// Top level of the double-sine degree-day core: thresholds, handshake and final sum.
// Throughput: one transaction per cycle while the output side takes results;
// each half-day has its own bank of SAMPLES_PER_HALF multiplier lanes, so
// 2 * SAMPLES_PER_HALF multipliers run in parallel.
// Reset (arst_n low) empties the pipeline and sets the thresholds to 0.0 and 40.0.
// Each stage holds its item while the next one is full and held too, so a waiting result
// never blocks input as long as an earlier stage has room.
module double_sine_degree_day_core #(
	parameter int SAMPLES_PER_HALF = dsdd_pkg::SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [dsdd_pkg::TEMP_W-1:0]         cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic signed [dsdd_pkg::TEMP_W-1:0]  min_today,
	input  logic signed [dsdd_pkg::TEMP_W-1:0]  max_today,
	input  logic signed [dsdd_pkg::TEMP_W-1:0]  min_tomorrow,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [dsdd_pkg::OUT_W-1:0]   degree_days
);
	import dsdd_pkg::*;

	localparam int         STAGES    = HALF_STAGES + 1;

	// Threshold registers. The user must change them only while the pipeline is empty;
	// the block does not enforce it. Every stage reads them directly, with no copy per item.
	temp_t lower_q;
	temp_t upper_q;
	temp_t upper_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= 16'sd10240;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOWER: lower_q <= cfg_data;
				REG_UPPER: upper_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// An upper cutoff below the lower threshold acts as equal to it.
	assign upper_eff = (upper_q < lower_q) ? lower_q : upper_q;

	// Valid bits, one per stage. A stage loads when it is empty or when the stage
	// after it moves on in the same cycle; the last stage moves on when the result
	// transaction completes.
	logic [STAGES:1]   valid_q;
	logic [STAGES+1:1] stage_en;

	always_comb begin
		stage_en[STAGES+1] = result_ready;
		for (int k = STAGES; k >= 1; k--) begin
			stage_en[k] = !valid_q[k] || stage_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (stage_en[1]) begin
				valid_q[1] <= item_valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (stage_en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign item_ready = stage_en[1];

	// The first half-day runs from today's minimum to the maximum, the second from
	// the maximum down to tomorrow's minimum.
	excess_t excess_a;
	excess_t excess_b;

	dsdd_half #(
		.SAMPLES_PER_HALF(SAMPLES_PER_HALF)
	) u_half_rise (
		.clk     (clk),
		.stage_en(stage_en[HALF_STAGES:1]),
		.s       (min_today),
		.e       (max_today),
		.lo      (lower_q),
		.hi      (upper_eff),
		.excess  (excess_a)
	);

	dsdd_half #(
		.SAMPLES_PER_HALF(SAMPLES_PER_HALF)
	) u_half_fall (
		.clk     (clk),
		.stage_en(stage_en[HALF_STAGES:1]),
		.s       (max_today),
		.e       (min_tomorrow),
		.lo      (lower_q),
		.hi      (upper_eff),
		.excess  (excess_b)
	);

	// Last stage: add both half-days and negate, as the result is reported as a
	// negative degree-day count.
	logic [EXCESS_W:0]       total_c;
	logic signed [OUT_W-1:0] degree_days_s8;

	assign total_c = {1'b0, excess_a} + {1'b0, excess_b};

	always_ff @(posedge clk) begin
		if (stage_en[STAGES]) begin
			degree_days_s8 <= OUT_W'(0) - OUT_W'(total_c);
		end
	end

	assign result_valid = valid_q[STAGES];
	assign degree_days  = degree_days_s8;

	// A result is never positive.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (degree_days[OUT_W-1] || degree_days == '0))
		else $error("degree_days result is positive");

	// With a free output side, the whole enable chain is open and input is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid || result_ready) |-> item_ready)
		else $error("input stalled although the output stage can drain");

	// With no band between the thresholds there is no excess at all.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && upper_q <= lower_q) |-> degree_days == '0)
		else $error("nonzero result with an empty threshold band");

endmodule

[dv/tb_double_sine_degree_day_core.sv]
// Self-checking testbench for the double-sine degree-day core, with its own integer predictor.
module tb_double_sine_degree_day_core;

	import dsdd_pkg::*;

	typedef logic signed [OUT_W-1:0] degree_days_t;

	// One daily record as it travels on the input channel.
	typedef struct packed {
		temp_t min_today;
		temp_t max_today;
		temp_t min_tomorrow;
	} day_record_t;

	localparam int SAMPLES          = SAMPLES_DEF;
	localparam int PIPE_LATENCY     = 8;
	localparam int SETTLE_CYCLES    = 2 * PIPE_LATENCY + 4;
	localparam int QUIET_LIMIT      = 2000;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int RANDOM_PER_PHASE = 110;
	localparam int MAX_REPORTS      = 10;

	// Sine samples over half a period, Q1.15, phase j/12 - 1/2 of pi.
	localparam longint HALF_SINE [12] = '{
		-32768, -31651, -28378, -23170, -16384, -8481,
		0, 8481, 16384, 23170, 28378, 31651
	};

	logic         clk          = 1'b0;
	logic         arst_n       = 1'b0;
	logic         cfg_we       = 1'b0;
	logic [0:0]   cfg_index    = REG_LOWER;
	logic [15:0]  cfg_data     = '0;
	logic         item_valid   = 1'b0;
	logic         item_ready;
	temp_t        min_today    = '0;
	temp_t        max_today    = '0;
	temp_t        min_tomorrow = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	degree_days_t degree_days;

	double_sine_degree_day_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.min_today    (min_today),
		.max_today    (max_today),
		.min_tomorrow (min_tomorrow),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.degree_days  (degree_days)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our copy of the threshold registers; they start at their reset values of 0.0 and 40.0.
	temp_t lower_q = 16'sd0;
	temp_t upper_q = 16'sd10240;

	// Records waiting to be offered, and degree-day values waiting to come out, oldest first.
	day_record_t  day_records [$];
	degree_days_t dd_expected [$];

	int records_accepted = 0;
	int results_checked  = 0;
	int mismatches       = 0;
	int settings_run     = 0;
	int input_stall_cycles = 0;
	bit sender_paced     = 1'b1;

	// Thermal excess of one half-day that runs from s to e, with thresholds lo and hi.
	// hi has already been raised to lo where it was set below it.
	function automatic longint half_day_excess(longint s, longint e, longint lo, longint hi);
		longint ampl;
		longint acc;
		longint point;
		int     k;
		int     phase;
		if (s <= lo && e <= lo)
			return 0;
		if (s >= hi && e >= hi)
			return hi - lo;
		// A flat half-day is taken as is, without the sample scaling.
		if (s == e)
			return s - lo;
		ampl = (s > e) ? s - e : e - s;
		acc  = 0;
		for (k = 0; k < SAMPLES; k++) begin
			phase = (k * 12) / SAMPLES;
			// The mean is kept in Q8.9, so sum plus amplitude times sine lands in Q.24;
			// the arithmetic shift rounds half up to Q8.8.
			point = ((s + e) * 32768 + ampl * HALF_SINE[phase] + 32768) >>> 16;
			if (point < lo)
				point = lo;
			if (point > hi)
				point = hi;
			acc += point - lo;
		end
		return (acc + SAMPLES) / (2 * SAMPLES);
	endfunction

	function automatic degree_days_t predict_degree_days(day_record_t rec);
		longint lo;
		longint hi;
		longint total;
		lo = lower_q;
		hi = upper_q;
		if (hi < lo)
			hi = lo;
		total = half_day_excess(rec.min_today, rec.max_today, lo, hi)
			+ half_day_excess(rec.max_today, rec.min_tomorrow, lo, hi);
		return degree_days_t'(-total);
	endfunction

	function automatic temp_t clamp_temp(int v);
		if (v < -32768)
			return temp_t'(-32768);
		if (v > 32767)
			return temp_t'(32767);
		return temp_t'(v);
	endfunction

	// Mostly temperatures around the thresholds, where the interesting cases live,
	// with raw 16-bit words and the corner values mixed in.
	function automatic temp_t pick_temp();
		int lo;
		int hi;
		lo = lower_q;
		hi = upper_q;
		if (hi < lo)
			hi = lo;
		case ($urandom_range(9))
			0, 1, 2: return temp_t'($urandom);
			3: begin
				case ($urandom_range(5))
					0: return temp_t'(-32768);
					1: return temp_t'(32767);
					2: return temp_t'(lo);
					3: return temp_t'(hi);
					4: return clamp_temp(lo + 1);
					default: return clamp_temp(hi - 1);
				endcase
			end
			default: return clamp_temp(lo - 1536 + int'($urandom_range(hi - lo + 3072)));
		endcase
	endfunction

	function automatic day_record_t random_record();
		day_record_t rec;
		temp_t       swap;
		rec.min_today    = pick_temp();
		rec.max_today    = pick_temp();
		rec.min_tomorrow = pick_temp();
		// Most days look like real weather: the maximum sits above both minima.
		if ($urandom_range(3) != 0) begin
			if (rec.max_today < rec.min_today) begin
				swap = rec.max_today;
				rec.max_today = rec.min_today;
				rec.min_today = swap;
			end
			if (rec.max_today < rec.min_tomorrow)
				rec.min_tomorrow = rec.max_today - temp_t'($urandom_range(1024));
		end
		// Flat half-days on either side.
		case ($urandom_range(9))
			0: rec.max_today = rec.min_today;
			1: rec.min_tomorrow = rec.max_today;
			default: ;
		endcase
		return rec;
	endfunction

	task automatic queue_record(int a, int b, int c);
		day_record_t rec;
		rec.min_today    = temp_t'(a);
		rec.max_today    = temp_t'(b);
		rec.min_tomorrow = temp_t'(c);
		day_records.push_back(rec);
	endtask

	// Both registers are written on back-to-back edges while the core is idle.
	task automatic set_thresholds(temp_t lo, temp_t hi);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LOWER;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_UPPER;
		cfg_data  <= hi;
		lower_q = lo;
		@(posedge clk);
		cfg_we <= 1'b0;
		upper_q = hi;
	endtask

	// Waits until every record has been taken and every result has come back,
	// then gives the pipeline time to show any stray result.
	task automatic drain_and_settle();
		while (day_records.size() != 0 || item_valid || dd_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One threshold setting: the corner days for these thresholds, then random days.
	task automatic run_setting(temp_t lo, temp_t hi, bit paced);
		int n;
		set_thresholds(lo, hi);
		@(negedge clk);
		sender_paced = paced;
		queue_record(32767, 32767, 32767);
		queue_record(-32768, -32768, -32768);
		queue_record(-32768, 32767, -32768);
		queue_record(lo, hi, lo);
		queue_record(hi, lo, hi);
		for (n = 0; n < RANDOM_PER_PHASE; n++)
			day_records.push_back(random_record());
		settings_run++;
		drain_and_settle();
	endtask

	// Sender state: records left in the current burst and idle cycles left in the gap.
	int          burst_left = 0;
	int          gap_left   = 0;
	bit          offering;
	day_record_t on_wire;

	// Driver. A record stays on the wires until its transaction completes; the expected
	// result is worked out at that edge, with the thresholds that are in force.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			offering = 1'b0;
			if (item_valid && item_ready) begin
				dd_expected.push_back(predict_degree_days(on_wire));
				records_accepted++;
			end
			if (item_valid && !item_ready) begin
				offering = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (day_records.size() != 0) begin
				if (burst_left == 0)
					burst_left = $urandom_range(32, 1);
				on_wire = day_records.pop_front();
				min_today    <= on_wire.min_today;
				max_today    <= on_wire.max_today;
				min_tomorrow <= on_wire.min_tomorrow;
				offering = 1'b1;
				burst_left--;
				// When paced, a third of the bursts run straight into the next one; unpaced, all do.
				if (burst_left == 0 && sender_paced && $urandom_range(2) != 0)
					gap_left = $urandom_range(24, 1);
			end
			item_valid <= offering;
		end
	end

	// Receiver state: a stall style that rx_cycle redraws periodically, plus one long hold-off.
	int rx_cycle     = 0;
	int rx_style     = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;

	task automatic report_mismatch(string what, degree_days_t want, degree_days_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("ERROR %0t: %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// Monitor. It checks each result transaction against the oldest expectation and
	// also decides result_ready for the next cycle.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (dd_expected.size() == 0) begin
					report_mismatch("result with no record pending", '0, degree_days);
				end else begin
					if (degree_days !== dd_expected[0])
						report_mismatch("degree_days", dd_expected[0], degree_days);
					void'(dd_expected.pop_front());
				end
				results_checked++;
			end

			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_style = $urandom_range(3);

			// Once, while the sender is busy, refuse results long enough for the core
			// to fill up and push back on its input.
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (!hold_done && results_checked >= 200 && item_valid) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
				result_ready <= 1'b0;
			end else begin
				case (rx_style)
					0: result_ready <= 1'b1;
					1: result_ready <= ($urandom_range(3) != 0);
					2: result_ready <= ((rx_cycle % 7) < 4);
					default: result_ready <= ($urandom_range(3) == 0);
				endcase
			end
		end
	end

	// Watchdog: ends the run if neither channel completes a transaction for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_ready)
				input_stall_cycles++;
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Sequencer: reset, then one phase per threshold setting.
	initial begin
		int n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed days under the reset thresholds (0.0 and 40.0), which are not written
		// here so that their reset values get checked.
		queue_record(-32768, -32768, -32768);
		queue_record(32767, 32767, 32767);
		queue_record(-32768, 32767, -32768);
		queue_record(32767, -32768, 32767);
		queue_record(2560, 2560, 2560);
		queue_record(-256, -512, -128);
		queue_record(10240, 10240, 10240);
		queue_record(0, 0, 0);
		queue_record(12000, 15000, 11000);
		queue_record(1280, 7680, 2560);
		queue_record(-1280, 5120, -2560);
		queue_record(5120, 15360, 6400);
		queue_record(-2000, 20000, -3000);
		queue_record(21845, -21846, 21845);
		queue_record(1000, 1001, 1000);
		queue_record(2560, 2560, 7680);
		queue_record(7680, 1280, 7680);
		queue_record(0, 10240, 0);
		queue_record(-1, 1, -1);
		queue_record(10239, 10241, 10239);
		for (n = 0; n < 100; n++)
			day_records.push_back(random_record());
		settings_run++;
		drain_and_settle();

		run_setting(16'sd2560, 16'sd7680, 1'b1);
		// Widest window: a day can reach the most negative result here.
		run_setting(-16'sd32768, 16'sd32767, 1'b0);
		// Upper threshold below the lower one collapses the window onto the lower.
		run_setting(16'sd5120, 16'sd2560, 1'b1);
		run_setting(16'sd32767, -16'sd32768, 1'b1);
		run_setting(16'sd0, 16'sd0, 1'b0);
		run_setting(16'sd32767, 16'sd32767, 1'b1);
		run_setting(-16'sd32768, -16'sd32768, 1'b1);
		run_setting(temp_t'($urandom), temp_t'($urandom), 1'b1);

		$display("Checked %0d degree-day results from %0d daily records over %0d threshold settings.",
			results_checked, records_accepted, settings_run);
		$display("Input was held back by the core for %0d cycles; %0d mismatches.",
			input_stall_cycles, mismatches);
		if (mismatches == 0 && dd_expected.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
